// ----- design/cau_pkg.sv -----
// Shared types and constants of the complex arithmetic unit.
// No dependencies.
package cau_pkg;

  localparam int ResW       = 32;
  localparam int MagW       = 24;
  localparam int StatusW    = 2;
  localparam int FuncW      = 2;
  localparam int InFrac     = 8;
  localparam int DivShift   = 16;
  localparam int PolarShift = 32 - InFrac;

  typedef enum logic [FuncW-1:0] {
    FUNC_ADD,
    FUNC_MUL,
    FUNC_DIV,
    FUNC_POLAR
  } func_e;

  typedef enum logic [StatusW-1:0] {
    STATUS_OK,
    STATUS_ZERO,
    STATUS_SAT
  } status_e;

endpackage

// ----- design/cau_sqrt_pipe.sv -----
// Pipelined floor square root, one result bit per register stage.
// Carries a side tag along with the data. No package dependencies.
module cau_sqrt_pipe #(
  parameter int RootW = 24,
  parameter int TagW  = 8
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               en_i,
  input  logic [2*RootW-1:0] rad_i,
  input  logic [TagW-1:0]    tag_i,
  output logic [RootW-1:0]   root_o,
  output logic [TagW-1:0]    tag_o
);

  localparam int RemW = RootW + 2;

  logic [2*RootW-1:0] rad_q  [RootW];
  logic [RemW-1:0]    rem_q  [RootW];
  logic [RootW-1:0]   root_q [RootW];
  logic [TagW-1:0]    tag_q  [RootW];

  for (genvar k = 0; k < RootW; k++) begin : g_stage
    logic [2*RootW-1:0] rad_in;
    logic [RemW-1:0]    rem_in;
    logic [RootW-1:0]   root_in;
    logic [TagW-1:0]    tag_in;
    logic [RemW-1:0]    cur;
    logic [RemW-1:0]    trial;
    logic [RemW-1:0]    diff;
    logic               ge;
    logic [2*RootW-1:0] rad_d;
    logic [RemW-1:0]    rem_d;
    logic [RootW-1:0]   root_d;

    if (k == 0) begin : g_first
      assign rad_in  = rad_i;
      assign rem_in  = '0;
      assign root_in = '0;
      assign tag_in  = tag_i;
    end else begin : g_next
      assign rad_in  = rad_q[k-1];
      assign rem_in  = rem_q[k-1];
      assign root_in = root_q[k-1];
      assign tag_in  = tag_q[k-1];
    end

    // bring down the next two radicand bits and try root*4+1
    assign cur    = {rem_in[RootW-1:0], rad_in[2*RootW-1 -: 2]};
    assign trial  = {root_in, 2'b01};
    assign ge     = (cur >= trial);
    assign diff   = cur - trial;
    assign rem_d  = ge ? diff : cur;
    assign root_d = {root_in[RootW-2:0], ge};
    assign rad_d  = rad_in << 2;

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rad_q[k]  <= rad_d;
        rem_q[k]  <= rem_d;
        root_q[k] <= root_d;
      end
    end
  end

  assign root_o = root_q[RootW-1];
  assign tag_o  = tag_q[RootW-1];

endmodule

// ----- design/cau_div_pipe.sv -----
// Pipelined restoring divider, two quotients over one shared divisor,
// one quotient bit per register stage. No package dependencies.
module cau_div_pipe #(
  parameter int NumW = 48,
  parameter int DenW = 32,
  parameter int TagW = 8
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            en_i,
  input  logic [NumW-1:0] num_re_i,
  input  logic [NumW-1:0] num_im_i,
  input  logic [DenW-1:0] den_i,
  input  logic [TagW-1:0] tag_i,
  output logic [NumW-1:0] quo_re_o,
  output logic [NumW-1:0] quo_im_o,
  output logic [TagW-1:0] tag_o
);

  logic [NumW-1:0] nq_q  [NumW][2];
  logic [DenW-1:0] rem_q [NumW][2];
  logic [DenW-1:0] den_q [NumW];
  logic [TagW-1:0] tag_q [NumW];

  for (genvar k = 0; k < NumW; k++) begin : g_stage
    logic [DenW-1:0] den_in;
    logic [TagW-1:0] tag_in;

    if (k == 0) begin : g_first
      assign den_in = den_i;
      assign tag_in = tag_i;
    end else begin : g_next
      assign den_in = den_q[k-1];
      assign tag_in = tag_q[k-1];
    end

    for (genvar l = 0; l < 2; l++) begin : g_lane
      logic [NumW-1:0] nq_in;
      logic [DenW-1:0] rem_in;
      logic [DenW:0]   cur;
      logic [DenW:0]   diff;
      logic            ge;
      logic [NumW-1:0] nq_d;
      logic [DenW-1:0] rem_d;

      if (k == 0) begin : g_first
        assign nq_in  = (l == 0) ? num_re_i : num_im_i;
        assign rem_in = '0;
      end else begin : g_next
        assign nq_in  = nq_q[k-1][l];
        assign rem_in = rem_q[k-1][l];
      end

      // shift in the next dividend bit, subtract if it fits
      assign cur   = {rem_in, nq_in[NumW-1]};
      assign diff  = cur - {1'b0, den_in};
      assign ge    = (cur >= {1'b0, den_in});
      assign rem_d = ge ? diff[DenW-1:0] : cur[DenW-1:0];
      assign nq_d  = {nq_in[NumW-2:0], ge};

      always_ff @(posedge clk_i) begin
        if (en_i) begin
          nq_q[k][l]  <= nq_d;
          rem_q[k][l] <= rem_d;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        tag_q[k] <= '0;
      end else if (en_i) begin
        tag_q[k] <= tag_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        den_q[k] <= den_in;
      end
    end
  end

  assign quo_re_o = nq_q[NumW-1][0];
  assign quo_im_o = nq_q[NumW-1][1];
  assign tag_o    = tag_q[NumW-1];

endmodule

// ----- design/complex_arithmetic_unit.sv -----
// Fixed-point complex arithmetic unit: add, multiply, divide, polar.
// Depends on cau_pkg, cau_sqrt_pipe and cau_div_pipe.
//
// Input channel: in_valid_i / in_stall_o with func_i and the two Q7.8
// operands a and b. Output channel: out_valid_o / out_stall_i with the
// Q15.16 result, the Q8.16 magnitude and the status code.
// Every item takes the same path: a multiply stage, a combine stage,
// IN_WIDTH+8 square-root stages, 2*IN_WIDTH+16 divider stages and an
// output stage.
// One item is accepted per cycle; the rate is set by the output register
// being free or taken in the same cycle.
// Results leave in the order the items came in.
// Reset empties the pipeline and clears out_valid_o.
// While the receiver stalls a held result, the whole pipeline holds and
// in_stall_o is raised; nothing is dropped or repeated.
module complex_arithmetic_unit #(
  parameter int IN_WIDTH = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  logic [cau_pkg::FuncW-1:0]        func_i,
  input  logic signed [IN_WIDTH-1:0]       a_re_i,
  input  logic signed [IN_WIDTH-1:0]       a_im_i,
  input  logic signed [IN_WIDTH-1:0]       b_re_i,
  input  logic signed [IN_WIDTH-1:0]       b_im_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output logic signed [cau_pkg::ResW-1:0]  res_re_o,
  output logic signed [cau_pkg::ResW-1:0]  res_im_o,
  output logic [cau_pkg::MagW-1:0]         magnitude_o,
  output logic [cau_pkg::StatusW-1:0]      status_o
);

  import cau_pkg::*;

  localparam int W  = IN_WIDTH;
  localparam int SW = W + 1;          // operand sum
  localparam int PW = 2 * W;          // product
  localparam int MW = 2 * W + 1;      // sum of products
  localparam int NW = 2 * W + 16;     // dividend / quotient magnitude
  localparam int RW = NW + 1;         // signed raw result
  localparam int SR = W + 8;          // square root
  localparam int DW = PW;             // divisor
  localparam int TagBW = 6 + 2 * RW + 2 * NW + DW;
  localparam int TagCW = 6 + 2 * RW + SR;

  localparam logic signed [RW-1:0] ResMax = {{(RW - 31){1'b0}}, {31{1'b1}}};
  localparam logic signed [RW-1:0] ResMin = {{(RW - 31){1'b1}}, {31{1'b0}}};

  logic en;

  // ---------------- stage A: products and sums ----------------
  func_e               func_in;
  logic                polar_in;
  logic signed [W-1:0] sq_x, sq_y;
  logic signed [PW-1:0] p_d [6];
  logic signed [SW-1:0] sre_d, sim_d;

  logic                 a_vld_q;
  func_e                a_func_q;
  logic signed [W-1:0]  a_re_q, a_im_q;
  logic signed [SW-1:0] a_sre_q, a_sim_q;
  logic signed [PW-1:0] a_p_q [6];

  assign func_in  = func_e'(func_i);
  assign polar_in = (func_in == FUNC_POLAR);
  assign sq_x     = polar_in ? a_re_i : b_re_i;
  assign sq_y     = polar_in ? a_im_i : b_im_i;
  assign p_d[0]   = a_re_i * b_re_i;
  assign p_d[1]   = a_im_i * b_im_i;
  assign p_d[2]   = a_re_i * b_im_i;
  assign p_d[3]   = a_im_i * b_re_i;
  assign p_d[4]   = sq_x * sq_x;
  assign p_d[5]   = sq_y * sq_y;
  assign sre_d    = SW'(a_re_i) + SW'(b_re_i);
  assign sim_d    = SW'(a_im_i) + SW'(b_im_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
    end else if (en) begin
      a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      a_func_q <= func_in;
      a_re_q   <= a_re_i;
      a_im_q   <= a_im_i;
      a_sre_q  <= sre_d;
      a_sim_q  <= sim_d;
      a_p_q    <= p_d;
    end
  end

  // ---------------- stage B: combine ----------------
  logic signed [MW-1:0] mul_re, mul_im, nr, ni;
  logic [PW-1:0]        ss;
  logic signed [RW-1:0] add_re, add_im, raw_re_d, raw_im_d;
  logic [PW-1:0]        nr_mag, ni_mag;
  logic [W-1:0]         ar_mag, ai_mag;
  logic [NW-1:0]        num_re_d, num_im_d;
  logic                 neg_re_d, neg_im_d, err_d, polar_a;
  logic [TagBW-1:0]     tag_b_d;

  logic [TagBW-1:0]     b_tag_q;
  logic [2*SR-1:0]      b_rad_q;

  assign polar_a = (a_func_q == FUNC_POLAR);
  assign mul_re  = MW'(a_p_q[0]) - MW'(a_p_q[1]);
  assign mul_im  = MW'(a_p_q[2]) + MW'(a_p_q[3]);
  assign nr      = MW'(a_p_q[0]) + MW'(a_p_q[1]);
  assign ni      = MW'(a_p_q[3]) - MW'(a_p_q[2]);
  assign ss      = $unsigned(a_p_q[4]) + $unsigned(a_p_q[5]);
  assign add_re  = RW'(a_sre_q) <<< InFrac;
  assign add_im  = RW'(a_sim_q) <<< InFrac;

  assign raw_re_d = (a_func_q == FUNC_ADD) ? add_re : RW'(mul_re);
  assign raw_im_d = (a_func_q == FUNC_ADD) ? add_im : RW'(mul_im);

  assign nr_mag = nr[MW-1] ? PW'(-nr) : PW'(nr);
  assign ni_mag = ni[MW-1] ? PW'(-ni) : PW'(ni);
  assign ar_mag = a_re_q[W-1] ? W'(-a_re_q) : W'(a_re_q);
  assign ai_mag = a_im_q[W-1] ? W'(-a_im_q) : W'(a_im_q);

  assign num_re_d = polar_a ? NW'({ar_mag, {PolarShift{1'b0}}})
                            : NW'({nr_mag, {DivShift{1'b0}}});
  assign num_im_d = polar_a ? NW'({ai_mag, {PolarShift{1'b0}}})
                            : NW'({ni_mag, {DivShift{1'b0}}});
  assign neg_re_d = polar_a ? a_re_q[W-1] : nr[MW-1];
  assign neg_im_d = polar_a ? a_im_q[W-1] : ni[MW-1];
  assign err_d    = ((a_func_q == FUNC_DIV) || polar_a) && (ss == '0);

  assign tag_b_d = {a_vld_q, a_func_q, err_d, neg_re_d, neg_im_d,
                    raw_re_d, raw_im_d, num_re_d, num_im_d, ss};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      b_tag_q <= '0;
    end else if (en) begin
      b_tag_q <= tag_b_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      b_rad_q <= {ss, {DivShift{1'b0}}};
    end
  end

  // ---------------- square root ----------------
  logic [SR-1:0]        root;
  logic [TagBW-1:0]     tag_s;
  logic                 s_vld, s_err, s_neg_re, s_neg_im;
  logic [FuncW-1:0]     s_func;
  logic signed [RW-1:0] s_raw_re, s_raw_im;
  logic [NW-1:0]        s_num_re, s_num_im;
  logic [DW-1:0]        s_den, divisor;
  logic [TagCW-1:0]     tag_c;

  cau_sqrt_pipe #(
    .RootW (SR),
    .TagW  (TagBW)
  ) u_sqrt (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .en_i   (en),
    .rad_i  (b_rad_q),
    .tag_i  (b_tag_q),
    .root_o (root),
    .tag_o  (tag_s)
  );

  assign {s_vld, s_func, s_err, s_neg_re, s_neg_im,
          s_raw_re, s_raw_im, s_num_re, s_num_im, s_den} = tag_s;

  assign divisor = (func_e'(s_func) == FUNC_POLAR) ? DW'(root) : s_den;
  assign tag_c   = {s_vld, s_func, s_err, s_neg_re, s_neg_im, s_raw_re, s_raw_im, root};

  // ---------------- division ----------------
  logic [NW-1:0]        quo_re, quo_im;
  logic [TagCW-1:0]     tag_q_out;
  logic                 d_vld, d_err, d_neg_re, d_neg_im;
  logic [FuncW-1:0]     d_func_raw;
  func_e                d_func;
  logic signed [RW-1:0] d_raw_re, d_raw_im;
  logic [SR-1:0]        d_root;

  cau_div_pipe #(
    .NumW (NW),
    .DenW (DW),
    .TagW (TagCW)
  ) u_div (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .en_i     (en),
    .num_re_i (s_num_re),
    .num_im_i (s_num_im),
    .den_i    (divisor),
    .tag_i    (tag_c),
    .quo_re_o (quo_re),
    .quo_im_o (quo_im),
    .tag_o    (tag_q_out)
  );

  assign {d_vld, d_func_raw, d_err, d_neg_re, d_neg_im,
          d_raw_re, d_raw_im, d_root} = tag_q_out;
  assign d_func = func_e'(d_func_raw);

  // ---------------- output stage: sign, clamp, status ----------------
  logic signed [RW-1:0] qv_re, qv_im, val_re, val_im;
  logic                 direct, polar_d, sat_re, sat_im, sat_mag;
  logic signed [ResW-1:0] res_re_d, res_im_d;
  logic [MagW-1:0]      mag_d;
  status_e              status_d;

  logic                 out_vld_q;
  logic signed [ResW-1:0] res_re_q, res_im_q;
  logic [MagW-1:0]      mag_q;
  status_e              status_q;

  assign direct  = (d_func == FUNC_ADD) || (d_func == FUNC_MUL);
  assign polar_d = (d_func == FUNC_POLAR);
  assign qv_re   = d_neg_re ? -RW'(quo_re) : RW'(quo_re);
  assign qv_im   = d_neg_im ? -RW'(quo_im) : RW'(quo_im);
  assign val_re  = direct ? d_raw_re : qv_re;
  assign val_im  = direct ? d_raw_im : qv_im;
  assign sat_re  = (val_re > ResMax) || (val_re < ResMin);
  assign sat_im  = (val_im > ResMax) || (val_im < ResMin);
  assign sat_mag = polar_d && ((d_root >> MagW) != '0);

  always_comb begin
    res_re_d = '0;
    res_im_d = '0;
    mag_d    = '0;
    status_d = STATUS_OK;
    if (d_err) begin
      status_d = STATUS_ZERO;
    end else begin
      if (val_re > ResMax) begin
        res_re_d = ResMax[ResW-1:0];
      end else if (val_re < ResMin) begin
        res_re_d = ResMin[ResW-1:0];
      end else begin
        res_re_d = val_re[ResW-1:0];
      end
      if (val_im > ResMax) begin
        res_im_d = ResMax[ResW-1:0];
      end else if (val_im < ResMin) begin
        res_im_d = ResMin[ResW-1:0];
      end else begin
        res_im_d = val_im[ResW-1:0];
      end
      if (polar_d) begin
        mag_d = sat_mag ? '1 : MagW'(d_root);
      end
      if (sat_re || sat_im || sat_mag) begin
        status_d = STATUS_SAT;
      end
    end
  end

  // advance everything when the output register is free or being taken
  assign en = !out_vld_q || !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (en) begin
      out_vld_q <= d_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      res_re_q <= res_re_d;
      res_im_q <= res_im_d;
      mag_q    <= mag_d;
      status_q <= status_d;
    end
  end

  assign in_stall_o  = !en;
  assign out_valid_o = out_vld_q;
  assign res_re_o    = res_re_q;
  assign res_im_o    = res_im_q;
  assign magnitude_o = mag_q;
  assign status_o    = status_q;

endmodule

// ----- verif/tb_top.sv -----
// Self-checking testbench for the complex arithmetic unit.
// Depends on cau_pkg and complex_arithmetic_unit; predicts each result in-line
// and compares every output transfer against the oldest pending prediction.
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import cau_pkg::*;

  localparam int InW       = 16;
  localparam int CycleLimit = 1000000;
  localparam int Latency   = 3 * InW + 27;

  typedef struct packed {
    logic signed [ResW-1:0] re;
    logic signed [ResW-1:0] im;
    logic [MagW-1:0]        mag;
    status_e                status;
  } cau_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [FuncW-1:0] func = '0;
  logic signed [InW-1:0] a_re = '0, a_im = '0, b_re = '0, b_im = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [ResW-1:0] res_re, res_im;
  logic [MagW-1:0] magnitude;
  logic [StatusW-1:0] status;

  cau_result_t pending_results[$];
  int unsigned mismatches = 0;
  int unsigned results_seen = 0;
  int unsigned items_sent = 0;
  int unsigned op_count[4] = '{0, 0, 0, 0};
  int unsigned cycles = 0;
  logic in_stall_s = 1'b0;
  bit no_gaps = 1'b0;
  bit no_stalls = 1'b0;
  int unsigned stall_left = 0;

  always #10 clk_i = ~clk_i;

  complex_arithmetic_unit #(.IN_WIDTH(InW)) dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall),
    .func_i      (func),
    .a_re_i      (a_re),
    .a_im_i      (a_im),
    .b_re_i      (b_re),
    .b_im_i      (b_im),
    .out_valid_o (out_valid),
    .out_stall_i (out_stall),
    .res_re_o    (res_re),
    .res_im_o    (res_im),
    .magnitude_o (magnitude),
    .status_o    (status)
  );

  function automatic longint unsigned floor_sqrt(longint unsigned x);
    longint unsigned r, bitv;
    r = 0;
    bitv = 64'd1 << 62;
    while (bitv > x) bitv = bitv >> 2;
    while (bitv != 0) begin
      if (x >= r + bitv) begin
        x = x - (r + bitv);
        r = (r >> 1) + bitv;
      end else begin
        r = r >> 1;
      end
      bitv = bitv >> 2;
    end
    return r;
  endfunction

  function automatic cau_result_t predict_complex(logic [FuncW-1:0] f,
      logic signed [InW-1:0] xr, logic signed [InW-1:0] xi,
      logic signed [InW-1:0] yr, logic signed [InW-1:0] yi);
    cau_result_t r;
    longint ar, ai, br, bi, re, im, den, nr, ni, md;
    longint unsigned s, m;
    bit sat, zero;
    ar = xr; ai = xi; br = yr; bi = yi;
    re = 0; im = 0; m = 0; sat = 0; zero = 0;
    case (func_e'(f))
      FUNC_ADD: begin
        re = (ar + br) * 256;
        im = (ai + bi) * 256;
      end
      FUNC_MUL: begin
        re = ar * br - ai * bi;
        im = ar * bi + ai * br;
      end
      FUNC_DIV: begin
        den = br * br + bi * bi;
        if (den == 0) begin
          zero = 1;
        end else begin
          nr = ar * br + ai * bi;
          ni = ai * br - ar * bi;
          re = (nr * 65536) / den;
          im = (ni * 65536) / den;
        end
      end
      default: begin
        s = longint'(ar * ar + ai * ai);
        if (s == 0) begin
          zero = 1;
        end else begin
          m = floor_sqrt(s << 16);
          md = longint'(m);
          re = (ar * (64'sd1 <<< PolarShift)) / md;
          im = (ai * (64'sd1 <<< PolarShift)) / md;
          if (m > 64'hFF_FFFF) begin
            m = 64'hFF_FFFF;
            sat = 1;
          end
        end
      end
    endcase
    // clamp both parts to the signed 32-bit range
    if (re > 64'sd2147483647) begin re = 64'sd2147483647; sat = 1; end
    if (re < -64'sd2147483648) begin re = -64'sd2147483648; sat = 1; end
    if (im > 64'sd2147483647) begin im = 64'sd2147483647; sat = 1; end
    if (im < -64'sd2147483648) begin im = -64'sd2147483648; sat = 1; end
    if (zero) begin
      r.re = '0; r.im = '0; r.mag = '0; r.status = STATUS_ZERO;
    end else begin
      r.re = re[ResW-1:0];
      r.im = im[ResW-1:0];
      r.mag = m[MagW-1:0];
      r.status = sat ? STATUS_SAT : STATUS_OK;
    end
    return r;
  endfunction

  // stall seen just before the edge decides whether the transfer happens
  always @(negedge clk_i) in_stall_s <= in_stall;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("timeout after %0d cycles, %0d results pending", cycles,
               pending_results.size());
      $display("complex_arithmetic_unit verification failed");
      $finish;
    end
  end

  // receiver: random stall runs, mostly short, a few long
  always @(posedge clk_i) begin
    if (no_stalls) begin
      out_stall <= 1'b0;
      stall_left <= 0;
    end else if (stall_left == 0) begin
      if ($urandom_range(0, 99) < 70) begin
        out_stall <= 1'b0;
        stall_left <= $urandom_range(1, 6);
      end else begin
        out_stall <= 1'b1;
        stall_left <= ($urandom_range(0, 9) == 0) ? $urandom_range(15, 40)
                                                   : $urandom_range(1, 3);
      end
    end else begin
      stall_left <= stall_left - 1;
    end
  end

  // outputs are registered and out_stall is driven at the edge, so both are
  // stable at the falling edge ahead of the transfer
  always @(negedge clk_i) begin
    cau_result_t want;
    if (rst_ni && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result re=%h im=%h mag=%h st=%0d",
                   res_re, res_im, magnitude, status);
      end else begin
        want = pending_results.pop_front();
        if (res_re !== want.re || res_im !== want.im || magnitude !== want.mag ||
            status !== want.status) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch #%0d: want re=%h im=%h mag=%h st=%0d, got re=%h im=%h mag=%h st=%0d",
                     results_seen, want.re, want.im, want.mag, want.status,
                     res_re, res_im, magnitude, status);
        end
      end
    end
  end

  task automatic send_item(logic [FuncW-1:0] f, logic signed [InW-1:0] xr,
      logic signed [InW-1:0] xi, logic signed [InW-1:0] yr,
      logic signed [InW-1:0] yi);
    int unsigned gap, pick;
    pick = $urandom_range(0, 99);
    gap = (no_gaps || pick < 50) ? 0 : (pick < 92) ? $urandom_range(1, 3)
                                                   : $urandom_range(10, 40);
    repeat (gap) begin
      in_valid <= 1'b0;
      @(posedge clk_i);
    end
    in_valid <= 1'b1;
    func <= f; a_re <= xr; a_im <= xi; b_re <= yr; b_im <= yi;
    @(posedge clk_i);
    while (in_stall_s) @(posedge clk_i);
    pending_results.push_back(predict_complex(f, xr, xi, yr, yi));
    items_sent++;
    op_count[f]++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic signed [InW-1:0] pick_operand();
    int unsigned k;
    k = $urandom_range(0, 9);
    case (k)
      0: return 16'sh7FFF;
      1: return 16'sh8000;
      2: return '0;
      3, 4: return InW'($signed($urandom_range(0, 64)) - 32);
      default: return InW'($urandom());
    endcase
  endfunction

  task automatic test_add_extremes();
    send_item(FUNC_ADD, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF, 16'sh7FFF);
    send_item(FUNC_ADD, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(FUNC_ADD, 16'sh0100, -16'sh0080, 16'sh7FFF, 16'sh8000);
  endtask

  task automatic test_mul_extremes();
    send_item(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh7FFF);
    send_item(FUNC_MUL, 16'sh7FFF, 16'sh8000, 16'sh7FFF, 16'sh8000);
    send_item(FUNC_MUL, 16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
    send_item(FUNC_MUL, 16'sh0100, 16'sh0000, 16'sh0000, 16'sh0100);
  endtask

  task automatic test_div_special();
    send_item(FUNC_DIV, 16'sh1234, 16'sh4321, 16'sh0000, 16'sh0000);
    send_item(FUNC_DIV, 16'sh7FFF, 16'sh7FFF, 16'sh0001, 16'sh0000);
    send_item(FUNC_DIV, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0001);
    send_item(FUNC_DIV, 16'sh8000, 16'sh7FFF, 16'sh8000, 16'sh8000);
    send_item(FUNC_DIV, -16'sh0100, 16'sh0100, 16'sh0300, -16'sh0200);
    send_item(FUNC_DIV, 16'sh0001, -16'sh0001, 16'sh0003, 16'sh0007);
  endtask

  task automatic test_polar_special();
    send_item(FUNC_POLAR, 16'sh0000, 16'sh0000, 16'sh7FFF, 16'sh7FFF);
    send_item(FUNC_POLAR, 16'sh8000, 16'sh8000, 16'sh0000, 16'sh0000);
    send_item(FUNC_POLAR, 16'sh7FFF, 16'sh7FFF, 16'sh8000, 16'sh0000);
    send_item(FUNC_POLAR, 16'sh0001, 16'sh0000, 16'sh0000, 16'sh0000);
    send_item(FUNC_POLAR, 16'sh0000, -16'sh0001, 16'sh0000, 16'sh0000);
    send_item(FUNC_POLAR, 16'sh0003, 16'sh0004, 16'sh0000, 16'sh0000);
    send_item(FUNC_POLAR, -16'sh0300, 16'sh0400, 16'sh0000, 16'sh0000);
  endtask

  task automatic test_random_mix(int unsigned count);
    for (int unsigned i = 0; i < count; i++) begin
      // one stretch with neither side idling, then a full drain pause
      no_gaps = (i >= count / 4 && i < count / 4 + 150);
      no_stalls = no_gaps;
      if (i == count / 2) wait_drained();
      send_item(FUNC_ADD + FuncW'($urandom_range(0, 3)), pick_operand(),
                pick_operand(), pick_operand(), pick_operand());
    end
    no_gaps = 0;
    no_stalls = 0;
  endtask

  initial begin
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_add_extremes();
    test_mul_extremes();
    test_div_special();
    test_polar_special();
    test_random_mix(1130);
    wait_drained();
    repeat (Latency + 20) @(posedge clk_i);
    $display("sent %0d items (add %0d, mul %0d, div %0d, polar %0d), checked %0d results",
             items_sent, op_count[0], op_count[1], op_count[2], op_count[3], results_seen);
    $display("%0d mismatches, %0d predictions left over", mismatches,
             pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("complex_arithmetic_unit verification clean");
    end else begin
      $display("complex_arithmetic_unit verification failed");
    end
    $finish;
  end

endmodule
